/* hw/rtl/spsv_pkg.sv */
// Package for the segmented prime sieve: sizes, widths, codes and state type.
// Used by every file of the block but spsv_ram; depends on nothing.
package spsv_pkg;

  localparam int SEGMENT_SIZE = 131072;
  localparam int BASE_LIMIT   = 32768;
  localparam int BASE_PRIMES  = 4096;
  localparam int VALUE_BITS   = 30;

  localparam int SEG_AW  = $clog2(SEGMENT_SIZE);
  localparam int SEG_CW  = SEG_AW + 1;
  localparam int BASE_AW = $clog2(BASE_LIMIT);
  localparam int BASE_CW = BASE_AW + 1;
  localparam int BP_AW   = $clog2(BASE_PRIMES);
  localparam int BP_CW   = BP_AW + 1;
  localparam int ROOT_W  = (VALUE_BITS + 1) / 2;
  localparam int REM_W   = BASE_AW;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_NEXT  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_PRIME = 2'd0,
    ST_DONE  = 2'd1,
    ST_ERROR = 2'd2,
    ST_START = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQRT,
    S_BFILL,
    S_BSEL,
    S_BCHK,
    S_BSTRIKE,
    S_CRD,
    S_CCHK,
    S_MFILL,
    S_TRD,
    S_TCHK,
    S_MOD,
    S_STRIKE,
    S_FRD,
    S_FCK,
    S_EMIT
  } state_t;

endpackage

/* hw/rtl/spsv_if.sv */
// Valid/ready channel interfaces for the command and result sides.
// Depends on spsv_pkg for the field widths.
interface spsv_in_if;
  logic                            valid;
  logic                            ready;
  logic                            cmd;
  logic [spsv_pkg::VALUE_BITS-1:0] range_low;
  logic [spsv_pkg::VALUE_BITS-1:0] range_high;
  modport source (output valid, cmd, range_low, range_high, input ready);
  modport sink   (input valid, cmd, range_low, range_high, output ready);
endinterface

interface spsv_out_if;
  logic                            valid;
  logic                            ready;
  logic [spsv_pkg::VALUE_BITS-1:0] prime_value;
  logic [1:0]                      status;
  modport source (output valid, prime_value, status, input ready);
  modport sink   (input valid, prime_value, status, output ready);
endinterface

/* hw/rtl/spsv_ram.sv */
// Generic single-clock RAM, one write and one read port, registered read data.
// Stand-alone; no package needed.
module spsv_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

/* hw/rtl/spsv_sqrt.sv */
// Iterative integer square root, one result bit per cycle.
// Depends on spsv_pkg for widths.
module spsv_sqrt (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [spsv_pkg::VALUE_BITS-1:0] value,
  output logic                            done,
  output logic [spsv_pkg::ROOT_W-1:0]     root
);
  import spsv_pkg::*;

  localparam int IDX_W = $clog2(ROOT_W);

  logic                  busy_r;
  logic                  done_r;
  logic [IDX_W-1:0]      idx_r;
  logic [ROOT_W-1:0]     root_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [ROOT_W-1:0]     trial;
  logic [2*ROOT_W-1:0]   trial_sq;

  assign trial    = root_r | (ROOT_W'(1) << idx_r);
  assign trial_sq = trial * trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        idx_r  <= IDX_W'(ROOT_W - 1);
        root_r <= '0;
        val_r  <= value;
      end else if (busy_r) begin
        if (trial_sq <= (2*ROOT_W)'(val_r)) begin
          root_r <= trial;
        end
        if (idx_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          idx_r <= idx_r - 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;
endmodule

/* hw/rtl/spsv_mod.sv */
// Restoring remainder unit: dividend modulo a base prime, one bit per cycle.
// Depends on spsv_pkg for widths.
module spsv_mod (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [spsv_pkg::VALUE_BITS-1:0] dividend,
  input  logic [spsv_pkg::REM_W-1:0]      divisor,
  output logic                            done,
  output logic [spsv_pkg::REM_W-1:0]      remainder
);
  import spsv_pkg::*;

  localparam int CNT_W = $clog2(VALUE_BITS);

  logic                  busy_r;
  logic                  done_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [VALUE_BITS-1:0] dvd_r;
  logic [REM_W-1:0]      dvs_r;
  logic [REM_W-1:0]      rem_r;
  logic [REM_W:0]        shifted;

  assign shifted = {rem_r, dvd_r[VALUE_BITS-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(VALUE_BITS - 1);
        dvd_r  <= dividend;
        dvs_r  <= divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        dvd_r <= {dvd_r[VALUE_BITS-2:0], 1'b0};
        if (shifted >= {1'b0, dvs_r}) begin
          rem_r <= REM_W'(shifted - {1'b0, dvs_r});
        end else begin
          rem_r <= REM_W'(shifted);
        end
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;
endmodule

/* hw/rtl/segmented_prime_sieve_core.sv */
// Segmented sieve of Eratosthenes. A start transaction (cmd 0) takes a range
// low..high, raises a low below 2 to 2, and answers with status 3, or status 2
// when high is below low or the span exceeds 131072 numbers. Preparing a range
// runs the square root, fills the base flag memory up to sqrt(high), runs the
// strikes of the small base sieve, collects base primes into the table, sets
// the mark of every segment number, and per base prime reads the table, runs
// the remainder unit and strikes each multiple in the segment. Each fetch
// transaction (cmd 1) then returns the next prime with status 0, or status 1
// when the range is used up; it scans the mark memory one number at a time,
// so the time follows the local prime gap. All work runs through one
// sequencer and memories with one read and one write port, so one transaction
// is handled at a time; the result sits in an output register, and the block
// takes the next transaction once that result has been loaded there.
// Depends on spsv_pkg, the channel interfaces, spsv_ram, spsv_sqrt, spsv_mod.
module segmented_prime_sieve_core (
  input  logic        clk,
  input  logic        rst_n,
  spsv_in_if.sink     in_ch,
  spsv_out_if.source  out_ch
);
  import spsv_pkg::*;

  state_t state_r, state_nxt;

  // Range and sequencing registers.
  logic [VALUE_BITS-1:0] lo_r;
  logic [SEG_CW-1:0]     span_r;
  logic [SEG_CW-1:0]     scan_r;
  logic                  ready_r;
  logic [BASE_AW-1:0]    limit_r;
  logic [BASE_CW-1:0]    p_r;
  logic [SEG_CW-1:0]     k_r;
  logic [BP_CW-1:0]      count_r;
  logic [BP_CW-1:0]      tidx_r;
  logic [BASE_AW-1:0]    pval_r;
  logic [SEG_CW-1:0]     off_r;

  // Pending result and output register.
  logic [VALUE_BITS-1:0] res_value_r;
  status_t               res_status_r;
  logic                  out_valid_r;
  logic [VALUE_BITS-1:0] out_value_r;
  status_t               out_status_r;

  // Memory controls.
  logic               flg_we, flg_re, flg_wdata, flg_rdata;
  logic [BASE_AW-1:0] flg_waddr, flg_raddr;
  logic               tbl_we, tbl_re;
  logic [BP_AW-1:0]   tbl_waddr, tbl_raddr;
  logic [BASE_AW-1:0] tbl_wdata, tbl_rdata;
  logic               mrk_we, mrk_re, mrk_wdata, mrk_rdata;
  logic [SEG_AW-1:0]  mrk_waddr, mrk_raddr;

  logic               sq_start, sq_done;
  logic [ROOT_W-1:0]  sq_root;
  logic               md_start, md_done;
  logic [REM_W-1:0]   md_rem;

  logic                  can_emit;
  logic                  in_acc;
  logic [VALUE_BITS-1:0] lo_raised;
  logic [VALUE_BITS:0]   span_full;
  logic [2*BASE_CW-1:0]  p_sq;
  logic [BASE_AW-1:0]    first_off;
  logic [VALUE_BITS:0]   first_val;
  logic [BASE_CW-1:0]    two_p;
  logic [SEG_CW-1:0]     strike_off;

  assign can_emit = !out_valid_r || out_ch.ready;
  assign in_acc   = in_ch.valid && in_ch.ready;

  assign lo_raised = (in_ch.range_low < VALUE_BITS'(2)) ? VALUE_BITS'(2) : in_ch.range_low;
  assign span_full = {1'b0, in_ch.range_high} - {1'b0, lo_raised} + (VALUE_BITS+1)'(1);

  assign p_sq = p_r * p_r;

  // First multiple at or above low is low plus (p - low mod p) mod p, but never
  // below 2p, so the prime itself stays unstruck.
  assign first_off  = (md_rem == '0) ? '0 : BASE_AW'(pval_r - md_rem);
  assign first_val  = {1'b0, lo_r} + (VALUE_BITS+1)'(first_off);
  assign two_p      = {pval_r, 1'b0};
  assign strike_off = (first_val < (VALUE_BITS+1)'(two_p))
                    ? SEG_CW'(two_p - BASE_CW'(lo_r))
                    : SEG_CW'(first_off);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.cmd == CMD_NEXT) begin
            state_nxt = ready_r ? S_FRD : S_EMIT;
          end else if (in_ch.range_high < in_ch.range_low) begin
            state_nxt = S_EMIT;
          end else if (in_ch.range_high < lo_raised) begin
            state_nxt = S_EMIT;
          end else if (span_full > (VALUE_BITS+1)'(SEGMENT_SIZE)) begin
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_SQRT;
          end
        end
      end
      S_SQRT:    if (sq_done) state_nxt = S_BFILL;
      S_BFILL:   if (k_r[BASE_AW-1:0] == limit_r) state_nxt = S_BSEL;
      S_BSEL:    state_nxt = (p_sq > (2*BASE_CW)'(limit_r)) ? S_CRD : S_BCHK;
      S_BCHK:    state_nxt = flg_rdata ? S_BSTRIKE : S_BSEL;
      S_BSTRIKE: if (k_r > SEG_CW'(limit_r)) state_nxt = S_BSEL;
      S_CRD:     state_nxt = (p_r > BASE_CW'(limit_r)) ? S_MFILL : S_CCHK;
      S_CCHK:    state_nxt = S_CRD;
      S_MFILL:   if (k_r == span_r - 1'b1) state_nxt = S_TRD;
      S_TRD:     state_nxt = (tidx_r == count_r) ? S_EMIT : S_TCHK;
      S_TCHK:    state_nxt = S_MOD;
      S_MOD:     if (md_done) state_nxt = S_STRIKE;
      S_STRIKE:  if (off_r >= span_r) state_nxt = S_TRD;
      S_FRD:     state_nxt = (scan_r >= span_r) ? S_EMIT : S_FCK;
      S_FCK:     state_nxt = mrk_rdata ? S_EMIT : S_FRD;
      S_EMIT:    if (can_emit) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Memory and unit controls.
  always_comb begin
    flg_we    = 1'b0;
    flg_waddr = k_r[BASE_AW-1:0];
    flg_wdata = 1'b0;
    flg_re    = 1'b0;
    flg_raddr = p_r[BASE_AW-1:0];
    tbl_we    = 1'b0;
    tbl_waddr = count_r[BP_AW-1:0];
    tbl_wdata = p_r[BASE_AW-1:0];
    tbl_re    = 1'b0;
    tbl_raddr = tidx_r[BP_AW-1:0];
    mrk_we    = 1'b0;
    mrk_waddr = k_r[SEG_AW-1:0];
    mrk_wdata = 1'b1;
    mrk_re    = 1'b0;
    mrk_raddr = scan_r[SEG_AW-1:0];
    sq_start  = 1'b0;
    md_start  = 1'b0;
    case (state_r)
      S_IDLE:    sq_start = (state_nxt == S_SQRT);
      S_BFILL: begin
        flg_we    = 1'b1;
        flg_wdata = (k_r >= SEG_CW'(2));
      end
      S_BSEL:    flg_re = 1'b1;
      S_BSTRIKE: flg_we = (k_r <= SEG_CW'(limit_r));
      S_CRD:     flg_re = 1'b1;
      S_CCHK:    tbl_we = flg_rdata && (count_r < BP_CW'(BASE_PRIMES));
      S_MFILL:   mrk_we = 1'b1;
      S_TRD:     tbl_re = 1'b1;
      S_TCHK:    md_start = 1'b1;
      S_STRIKE: begin
        mrk_we    = (off_r < span_r);
        mrk_waddr = off_r[SEG_AW-1:0];
        mrk_wdata = 1'b0;
      end
      S_FRD:     mrk_re = 1'b1;
      default: ;
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ready_r     <= 1'b0;
      scan_r      <= '0;
      span_r      <= '0;
      lo_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // The output register fills from the emit state and drains on ready.
      if (state_r == S_EMIT && can_emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            res_value_r <= '0;
            if (in_ch.cmd == CMD_NEXT) begin
              res_status_r <= ST_DONE;
            end else begin
              ready_r <= 1'b0;
              scan_r  <= '0;
              if (in_ch.range_high < in_ch.range_low) begin
                res_status_r <= ST_ERROR;
              end else if (in_ch.range_high < lo_raised) begin
                // Empty range: accepted, but nothing to report.
                ready_r      <= 1'b1;
                span_r       <= '0;
                lo_r         <= lo_raised;
                res_status_r <= ST_START;
              end else if (span_full > (VALUE_BITS+1)'(SEGMENT_SIZE)) begin
                res_status_r <= ST_ERROR;
              end else begin
                lo_r         <= lo_raised;
                span_r       <= SEG_CW'(span_full);
                res_status_r <= ST_START;
              end
            end
          end
        end
        S_SQRT: begin
          if (sq_done) begin
            // The root of a full-width value already stays below the base limit.
            limit_r <= BASE_AW'(sq_root);
            k_r     <= '0;
            count_r <= '0;
            p_r     <= BASE_CW'(2);
          end
        end
        S_BFILL:   k_r <= k_r + 1'b1;
        S_BCHK: begin
          if (flg_rdata) begin
            k_r <= SEG_CW'(p_sq);
          end else begin
            p_r <= p_r + 1'b1;
          end
        end
        S_BSEL: begin
          if (p_sq > (2*BASE_CW)'(limit_r)) begin
            p_r <= BASE_CW'(2);
          end
        end
        S_BSTRIKE: begin
          if (k_r > SEG_CW'(limit_r)) begin
            p_r <= p_r + 1'b1;
          end else begin
            k_r <= k_r + SEG_CW'(p_r);
          end
        end
        S_CRD: begin
          if (p_r > BASE_CW'(limit_r)) begin
            k_r    <= '0;
            tidx_r <= '0;
          end
        end
        S_CCHK: begin
          if (tbl_we) begin
            count_r <= count_r + 1'b1;
          end
          p_r <= p_r + 1'b1;
        end
        S_MFILL:   k_r <= k_r + 1'b1;
        S_TRD: begin
          if (tidx_r == count_r) begin
            ready_r <= 1'b1;
          end
        end
        S_TCHK:    pval_r <= tbl_rdata;
        S_MOD: begin
          if (md_done) begin
            off_r  <= strike_off;
            tidx_r <= tidx_r + 1'b1;
          end
        end
        S_STRIKE:  off_r <= off_r + SEG_CW'(pval_r);
        S_FRD: begin
          if (scan_r >= span_r) begin
            res_status_r <= ST_DONE;
            res_value_r  <= '0;
          end else begin
            scan_r <= scan_r + 1'b1;
          end
        end
        S_FCK: begin
          if (mrk_rdata) begin
            res_status_r <= ST_PRIME;
            res_value_r  <= lo_r + VALUE_BITS'(scan_r) - VALUE_BITS'(1);
          end
        end
        S_EMIT: begin
          if (can_emit) begin
            out_value_r  <= res_value_r;
            out_status_r <= res_status_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.prime_value = out_value_r;
  assign out_ch.status      = out_status_r;

  spsv_ram #(.WIDTH(1), .DEPTH(BASE_LIMIT)) u_flags (
    .clk(clk), .we(flg_we), .waddr(flg_waddr), .wdata(flg_wdata),
    .re(flg_re), .raddr(flg_raddr), .rdata(flg_rdata)
  );

  spsv_ram #(.WIDTH(BASE_AW), .DEPTH(BASE_PRIMES)) u_table (
    .clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
    .re(tbl_re), .raddr(tbl_raddr), .rdata(tbl_rdata)
  );

  spsv_ram #(.WIDTH(1), .DEPTH(SEGMENT_SIZE)) u_marks (
    .clk(clk), .we(mrk_we), .waddr(mrk_waddr), .wdata(mrk_wdata),
    .re(mrk_re), .raddr(mrk_raddr), .rdata(mrk_rdata)
  );

  spsv_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .value(in_ch.range_high),
    .done(sq_done), .root(sq_root)
  );

  spsv_mod u_mod (
    .clk(clk), .rst_n(rst_n), .start(md_start), .dividend(lo_r),
    .divisor(tbl_rdata), .done(md_done), .remainder(md_rem)
  );

  // A reported prime always lies at or above two.
  a_prime_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_PRIME) |-> (out_value_r >= VALUE_BITS'(2)))
    else $error("prime result below two");

  // Any status other than a prime carries a zero value.
  a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_PRIME) |-> (out_value_r == '0))
    else $error("non-prime result with nonzero value");

  // Strikes never touch marks outside the prepared segment.
  a_strike_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    (mrk_we && !mrk_wdata) |-> ({1'b0, mrk_waddr} < span_r))
    else $error("strike outside segment");

  // The scan pointer never runs past the end of a prepared segment.
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ready_r |-> (scan_r <= span_r))
    else $error("scan position beyond segment");

  // A new result is loaded only when the output register is free or draining.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(out_value_r)))
    else $error("pending result overwritten");
endmodule

/* sim/tb_segmented_prime_sieve_core.sv */
// Self-checking testbench for segmented_prime_sieve_core: start and fetch traffic
// against a prime-scanning scoreboard, with bursty sending and stalled receiving.
// Depends on spsv_pkg, spsv_in_if and spsv_out_if from the RTL.
`timescale 1ns / 1ps

module tb_segmented_prime_sieve_core;
  import spsv_pkg::*;

  localparam int           RANDOM_ITEMS = 1200;
  localparam longint       CYCLE_LIMIT  = 6000000;
  localparam int           DRAIN_CYCLES = 200;
  localparam int unsigned  VALUE_MAX    = (1 << VALUE_BITS) - 1;

  typedef struct {
    logic [VALUE_BITS-1:0] prime_value;
    status_t               status;
  } sieve_result_t;

  // Tracks the prepared range and scan offset of the block and queues the
  // result that each accepted transaction must produce.
  class prime_scoreboard;
    bit            range_ready;
    longint        range_lo;
    longint        range_hi;
    longint        scan_pos;
    sieve_result_t pending[$];

    function new();
      range_ready = 0;
      range_lo    = 0;
      range_hi    = 0;
      scan_pos    = 0;
    endfunction

    // Trial division; only numbers at or above two are ever asked about.
    function bit is_prime(longint n);
      longint d;
      if (n < 2) return 0;
      for (d = 2; d * d <= n; d++)
        if (n % d == 0) return 0;
      return 1;
    endfunction

    function void push(longint value, status_t st);
      sieve_result_t r;
      r.prime_value = value[VALUE_BITS-1:0];
      r.status      = st;
      pending.insert(pending.size(), r);
    endfunction

    function void note_input(cmd_t cmd, logic [VALUE_BITS-1:0] lo_in,
                             logic [VALUE_BITS-1:0] hi_in);
      longint lo, hi, span, n;
      lo = lo_in;
      hi = hi_in;
      if (cmd == CMD_START) begin
        range_ready = 0;
        scan_pos    = 0;
        if (hi < lo) begin
          push(0, ST_ERROR);
          return;
        end
        if (lo < 2) lo = 2;
        span = (hi >= lo) ? hi - lo + 1 : 0;
        if (span > SEGMENT_SIZE) begin
          push(0, ST_ERROR);
          return;
        end
        range_lo    = lo;
        range_hi    = hi;
        range_ready = 1;
        push(0, ST_START);
      end else begin
        if (!range_ready || range_hi < range_lo) begin
          push(0, ST_DONE);
          return;
        end
        span = range_hi - range_lo + 1;
        if (span > SEGMENT_SIZE) span = SEGMENT_SIZE;
        while (scan_pos < span) begin
          n = range_lo + scan_pos;
          scan_pos++;
          if (is_prime(n)) begin
            push(n, ST_PRIME);
            return;
          end
        end
        push(0, ST_DONE);
      end
    endfunction

    // Returns an empty string on a match, otherwise a description.
    function string check_result(logic [VALUE_BITS-1:0] value, logic [1:0] st);
      sieve_result_t e;
      if (pending.size() == 0)
        return $sformatf("unexpected result value=%0d status=%0d", value, st);
      e = pending.pop_front();
      if (st !== e.status || value !== e.prime_value)
        return $sformatf("got value=%0d status=%0d, want value=%0d status=%0d",
                         value, st, e.prime_value, e.status);
      return "";
    endfunction
  endclass

  logic clk;
  logic rst_n;

  spsv_in_if  in_ch();
  spsv_out_if out_ch();

  segmented_prime_sieve_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  prime_scoreboard sb = new();
  int     error_count = 0;
  longint cycle_count = 0;
  int     burst_left  = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Every input starts at a known value; reset is held low until the main sequence releases it.
  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.cmd       = CMD_NEXT;
    in_ch.range_low = '0;
    in_ch.range_high = '0;
    out_ch.ready    = 1'b0;
  end

  task automatic report_mismatch(string msg);
    error_count++;
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
  endtask

  // A global cycle counter guards against a hung block.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Input and output monitors. The scoreboard sees every accepted transaction
  // in order, so the expected results line up with the block's results.
  always @(posedge clk) begin
    string msg;
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_input(cmd_t'(in_ch.cmd), in_ch.range_low, in_ch.range_high);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      msg = sb.check_result(out_ch.prime_value, out_ch.status);
      if (msg != "") report_mismatch(msg);
    end
  end

  // The receiver alternates between long streaks of readiness, random
  // stalls and short hard stalls, changing mode every so often.
  int stall_mode = 0;
  int mode_left  = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(5, 80);
      end
      mode_left = mode_left - 1;
      case (stall_mode)
        0: begin
          out_ch.ready <= 1'b1;
        end
        1: begin
          out_ch.ready <= ($urandom_range(0, 1) == 1);
        end
        default: begin
          out_ch.ready <= (mode_left % 7 == 0);
        end
      endcase
    end
  end

  // Sends one transaction. Within a burst valid stays high from one item to
  // the next; at the end of a burst it drops for a random gap.
  task automatic send_item(cmd_t cmd, int unsigned lo, int unsigned hi);
    @(negedge clk);
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= cmd;
    in_ch.range_low  <= lo[VALUE_BITS-1:0];
    in_ch.range_high <= hi[VALUE_BITS-1:0];
    do @(posedge clk); while (!in_ch.ready);
    if (burst_left == 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(0, 12)) @(negedge clk);
      burst_left = $urandom_range(0, 10);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_fetch();
    send_item(CMD_NEXT, $urandom() & VALUE_MAX, $urandom() & VALUE_MAX);
  endtask

  // Random part: mostly small well-formed ranges followed by fetches, with
  // some running past exhaustion; the rest are malformed starts and noise.
  task automatic run_random();
    int          sent;
    int unsigned lo, hi, kind, fetches;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        hi = $urandom_range(2, 20000);
        lo = (hi > 300) ? hi - $urandom_range(0, 300) : $urandom_range(1, hi);
        if ($urandom_range(0, 9) == 0) lo = 1;
        send_item(CMD_START, lo, hi);
        fetches = $urandom_range(1, 40);
        repeat (fetches) send_fetch();
        sent += fetches + 1;
      end else if (kind < 80) begin
        // Full-width values with high below low exercise every field bit.
        lo = $urandom() & VALUE_MAX;
        hi = $urandom() & VALUE_MAX;
        if (hi >= lo) begin
          lo = hi | 1;
          hi = lo - 1;
        end
        if (lo == 0) lo = 1;
        send_item(CMD_START, lo, hi);
        sent++;
      end else if (kind < 88) begin
        lo = $urandom_range(1, VALUE_MAX - SEGMENT_SIZE - 1000);
        hi = lo + SEGMENT_SIZE + $urandom_range(0, 900);
        send_item(CMD_START, lo, hi);
        sent++;
      end else begin
        send_fetch();
        sent++;
      end
    end
  endtask

  initial begin
    int wait_cycles;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part.
    send_item(CMD_NEXT, VALUE_MAX, VALUE_MAX);            // fetch before any start
    send_item(CMD_START, VALUE_MAX, 1);                   // high below low
    send_fetch();                                         // fetch after an error
    send_item(CMD_START, 5, 5 + SEGMENT_SIZE);            // span one too wide
    send_item(CMD_START, 1, SEGMENT_SIZE + 2);            // too wide after raising
    send_item(CMD_START, 1, 1);                           // empty range below two
    send_fetch();
    send_item(CMD_START, 0, 0);                           // zero bounds, empty range
    send_fetch();
    send_item(CMD_START, 1, 30);                          // raised low, run past end
    repeat (12) send_fetch();
    send_item(CMD_START, 2, 2);
    send_fetch();
    send_fetch();
    send_item(CMD_START, VALUE_MAX - 15, VALUE_MAX);      // largest base limit
    repeat (4) send_fetch();

    run_random();

    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait_cycles = 0;
    while (sb.pending.size() != 0) begin
      @(posedge clk);
      wait_cycles++;
      if (wait_cycles > 2000000) begin
        $display("Timeout waiting for %0d results", sb.pending.size());
        $display("Test completed with failures");
        $finish;
      end
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
